// File: hdl/foc_pkg.sv
`default_nettype none

package foc_pkg;

	typedef logic signed [15:0] q15_t;

	// alpha/beta voltage after inverse Park, kept wide (no saturation)
	typedef logic signed [17:0] volt_ab_t;

	localparam logic [15:0] PWM_PERIOD_RESET = 16'd4250;

	localparam logic signed [15:0] INV_SQRT3_Q15  = 16'sd18919;
	localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;

endpackage

`default_nettype wire

// File: hdl/foc_sincos.sv
`default_nettype none

module foc_sincos #(
	parameter int DEPTH = 1024
) (
	input  logic             clk,
	input  logic             ce,
	input  logic [15:0]      angle,
	output foc_pkg::q15_t    sin_s3,
	output foc_pkg::q15_t    cos_s3
);

	localparam int IW = $clog2(DEPTH + 1);
	localparam int PW = 14 + IW;

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	typedef logic [14:0] rom_t [0:DEPTH];

	// quarter-wave sine, Q15, Taylor series to x^13 in Q30
	function automatic logic [14:0] sine_entry(input logic [31:0] k);
		logic [63:0]        t;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        r;
		logic signed [63:0] sum;
		t    = (64'(k) << 30) / 64'(DEPTH);
		x    = (t * 64'd1686629713) >> 30;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + $signed(term);
		if (sum < 0) begin
			sum = 0;
		end
		r = ($unsigned(sum) * 64'd32767 + 64'd536870912) >> 30;
		if (r > 64'd32767) begin
			r = 64'd32767;
		end
		return 15'(r);
	endfunction

	function automatic rom_t build_rom();
		rom_t rom;
		for (int k = 0; k <= DEPTH; k++) begin
			rom[k] = sine_entry(32'(k));
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [PW-1:0] scaled;
	logic [IW-1:0] idx;
	logic [1:0]    quad_s1;
	logic [1:0]    quad_s2;
	logic [IW-1:0] addr_s_s1;
	logic [IW-1:0] addr_c_s1;
	logic [14:0]   sv_s2;
	logic [14:0]   cv_s2;
	foc_pkg::q15_t sv16;
	foc_pkg::q15_t cv16;

	assign scaled = PW'(angle[13:0]) * PW'(DEPTH);
	assign idx    = IW'(scaled >> 14);

	always_ff @(posedge clk) begin
		if (ce) begin
			quad_s1   <= angle[15:14];
			addr_s_s1 <= idx;
			addr_c_s1 <= IW'(DEPTH) - idx;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			quad_s2 <= quad_s1;
			sv_s2   <= SINE_ROM[addr_s_s1];
			cv_s2   <= SINE_ROM[addr_c_s1];
		end
	end

	assign sv16 = $signed({1'b0, sv_s2});
	assign cv16 = $signed({1'b0, cv_s2});

	always_ff @(posedge clk) begin
		if (ce) begin
			case (quad_s2)
				QUAD_I: begin
					sin_s3 <= sv16;
					cos_s3 <= cv16;
				end
				QUAD_II: begin
					sin_s3 <= cv16;
					cos_s3 <= -sv16;
				end
				QUAD_III: begin
					sin_s3 <= -sv16;
					cos_s3 <= -cv16;
				end
				QUAD_IV: begin
					sin_s3 <= -cv16;
					cos_s3 <= sv16;
				end
				default: begin
					sin_s3 <= '0;
					cos_s3 <= '0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hdl/foc_park.sv
`default_nettype none

module foc_park (
	input  logic              clk,
	input  logic              ce,
	input  foc_pkg::q15_t     current_a,
	input  foc_pkg::q15_t     current_b,
	input  foc_pkg::q15_t     current_c,
	input  foc_pkg::q15_t     volt_d,
	input  foc_pkg::q15_t     volt_q,
	input  foc_pkg::q15_t     sin_s3,
	input  foc_pkg::q15_t     cos_s3,
	output foc_pkg::q15_t     current_d_s5,
	output foc_pkg::q15_t     current_q_s5,
	output foc_pkg::volt_ab_t volt_alpha_s5,
	output foc_pkg::volt_ab_t volt_beta_s5
);

	function automatic foc_pkg::q15_t sat16(input logic signed [32:0] v);
		if (v > 33'sd32767) begin
			return 16'sh7fff;
		end else if (v < -33'sd32768) begin
			return 16'sh8000;
		end
		return 16'(v);
	endfunction

	foc_pkg::q15_t      alpha_s1, alpha_s2, alpha_s3;
	foc_pkg::q15_t      vd_s1, vd_s2, vd_s3;
	foc_pkg::q15_t      vq_s1, vq_s2, vq_s3;
	logic signed [16:0] diff_s1;
	logic signed [31:0] bprod_s2;
	logic signed [16:0] beta_s3;
	logic signed [31:0] ac_s4, bs_s4, bc_s4, asn_s4;
	logic signed [31:0] vdc_s4, vqs_s4, vds_s4, vqc_s4;
	logic signed [32:0] id_sum, iq_sum, va_sum, vb_sum;

	// Clarke: alpha = a, beta = (b - c) / sqrt3
	always_ff @(posedge clk) begin
		if (ce) begin
			alpha_s1 <= current_a;
			diff_s1  <= 17'(current_b) - 17'(current_c);
			vd_s1    <= volt_d;
			vq_s1    <= volt_q;

			alpha_s2 <= alpha_s1;
			bprod_s2 <= 32'(diff_s1) * 32'(foc_pkg::INV_SQRT3_Q15);
			vd_s2    <= vd_s1;
			vq_s2    <= vq_s1;

			alpha_s3 <= alpha_s2;
			beta_s3  <= 17'((bprod_s2 + 32'sd16384) >>> 15);
			vd_s3    <= vd_s2;
			vq_s3    <= vq_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			ac_s4  <= 32'(alpha_s3) * 32'(cos_s3);
			bs_s4  <= 32'(beta_s3) * 32'(sin_s3);
			bc_s4  <= 32'(beta_s3) * 32'(cos_s3);
			asn_s4 <= 32'(alpha_s3) * 32'(sin_s3);
			vdc_s4 <= 32'(vd_s3) * 32'(cos_s3);
			vqs_s4 <= 32'(vq_s3) * 32'(sin_s3);
			vds_s4 <= 32'(vd_s3) * 32'(sin_s3);
			vqc_s4 <= 32'(vq_s3) * 32'(cos_s3);
		end
	end

	always_comb begin
		id_sum = 33'(ac_s4) + 33'(bs_s4) + 33'sd16384;
		iq_sum = 33'(bc_s4) - 33'(asn_s4) + 33'sd16384;
		va_sum = 33'(vdc_s4) - 33'(vqs_s4) + 33'sd16384;
		vb_sum = 33'(vds_s4) + 33'(vqc_s4) + 33'sd16384;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			current_d_s5  <= sat16(id_sum >>> 15);
			current_q_s5  <= sat16(iq_sum >>> 15);
			volt_alpha_s5 <= 18'(va_sum >>> 15);
			volt_beta_s5  <= 18'(vb_sum >>> 15);
		end
	end

endmodule

`default_nettype wire

// File: hdl/foc_svpwm.sv
`default_nettype none

module foc_svpwm (
	input  logic              clk,
	input  logic              ce,
	input  foc_pkg::volt_ab_t volt_alpha_s5,
	input  foc_pkg::volt_ab_t volt_beta_s5,
	input  logic [15:0]       pwm_period,
	output logic [2:0][15:0]  compare_s12
);

	// clamp Q31 duty to 0..1.0; scaling then never exceeds the period
	function automatic logic [31:0] clamp_duty(input logic signed [35:0] d);
		if (d < 36'sd0) begin
			return 32'd0;
		end else if (d > 36'sd2147483648) begin
			return 32'h8000_0000;
		end
		return 32'(d);
	endfunction

	foc_pkg::volt_ab_t  valpha_s6;
	logic signed [33:0] k_s6;
	logic signed [33:0] half;
	logic signed [33:0] v_s7 [3];
	logic signed [33:0] v_s8 [3];
	logic signed [33:0] v_s9 [3];
	logic signed [33:0] vmax, vmin;
	logic signed [33:0] vmax_s8, vmin_s8;
	logic signed [35:0] cm_s9;
	logic [31:0]        duty_s10 [3];
	logic [47:0]        prod_s11 [3];

	always_ff @(posedge clk) begin
		if (ce) begin
			valpha_s6 <= volt_alpha_s5;
			k_s6      <= 34'(volt_beta_s5) * 34'(foc_pkg::SQRT3_HALF_Q15);
		end
	end

	// phase vectors, Q30
	assign half = 34'(valpha_s6) <<< 14;

	always_ff @(posedge clk) begin
		if (ce) begin
			v_s7[0] <= 34'(valpha_s6) <<< 15;
			v_s7[1] <= k_s6 - half;
			v_s7[2] <= -(k_s6 + half);
		end
	end

	always_comb begin
		vmax = v_s7[0];
		vmin = v_s7[0];
		for (int i = 1; i < 3; i++) begin
			if (v_s7[i] > vmax) begin
				vmax = v_s7[i];
			end
			if (v_s7[i] < vmin) begin
				vmin = v_s7[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			vmax_s8 <= vmax;
			vmin_s8 <= vmin;
			cm_s9   <= 36'(vmax_s8) + 36'(vmin_s8) + 36'sd1073741824;
			for (int i = 0; i < 3; i++) begin
				v_s8[i]        <= v_s7[i];
				v_s9[i]        <= v_s8[i];
				duty_s10[i]    <= clamp_duty(cm_s9 - (36'(v_s9[i]) <<< 1));
				prod_s11[i]    <= 48'(duty_s10[i]) * 48'(pwm_period);
				compare_s12[i] <= 16'((prod_s11[i] + 48'd1073741824) >> 31);
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/foc_transform_svpwm.sv
// Channel | Dir | Fields (low bit first)
// s_*     | in  | tdata: rotor_angle, current_a, current_b, current_c, volt_d, volt_q
// m_*     | out | tdata: current_d, current_q, compare_a, compare_b, compare_c
// cfg_*   | in  | wr_data: pwm_period, written when cfg_wr_en is high
//
// One item per cycle while a stall on m_tready does not hold the pipeline. 12 pipeline
// stages (s1 to s12) plus the output register, which each item passes before it shows on m_tvalid.
// The throughput is set by the fully pipelined datapath, whose sine ROM has
// two registered read ports, one for each of sine and cosine.
// Reset clears all valid bits and loads pwm_period with 4250.
// A stall on m_tready parks one item in the skid register; s_tready drops
// while it is full and the whole pipeline holds.
`default_nettype none

module foc_transform_svpwm #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,     // rotor_angle, current_a, current_b, current_c, volt_d, volt_q
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,     // current_d, current_q, compare_a, compare_b, compare_c
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data  // pwm_period
);

	localparam int LAT      = 12;
	localparam int PARK_LAT = 5;

	logic              pipe_ce;
	logic [LAT:1]      valid_s;
	logic [15:0]       pwm_period_q;
	foc_pkg::q15_t     sin_s3, cos_s3;
	foc_pkg::q15_t     park_d_s5, park_q_s5;
	foc_pkg::volt_ab_t valpha_s5, vbeta_s5;
	foc_pkg::q15_t     cur_d_s [PARK_LAT+1:LAT];
	foc_pkg::q15_t     cur_q_s [PARK_LAT+1:LAT];
	logic [2:0][15:0]  compare_s12;
	logic [79:0]       result_s12;
	logic              out_valid_q, skid_valid_q;
	logic [79:0]       out_data_q, skid_data_q;

	assign pipe_ce  = !skid_valid_q;
	assign s_tready = pipe_ce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q <= foc_pkg::PWM_PERIOD_RESET;
		end else if (cfg_wr_en) begin
			pwm_period_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (pipe_ce) begin
			valid_s <= {valid_s[LAT-1:1], s_tvalid};
		end
	end

	foc_sincos #(
		.DEPTH (SINE_TABLE_DEPTH)
	) u_sincos (
		.clk    (clk),
		.ce     (pipe_ce),
		.angle  (s_tdata[15:0]),
		.sin_s3 (sin_s3),
		.cos_s3 (cos_s3)
	);

	foc_park u_park (
		.clk           (clk),
		.ce            (pipe_ce),
		.current_a     (s_tdata[31:16]),
		.current_b     (s_tdata[47:32]),
		.current_c     (s_tdata[63:48]),
		.volt_d        (s_tdata[79:64]),
		.volt_q        (s_tdata[95:80]),
		.sin_s3        (sin_s3),
		.cos_s3        (cos_s3),
		.current_d_s5  (park_d_s5),
		.current_q_s5  (park_q_s5),
		.volt_alpha_s5 (valpha_s5),
		.volt_beta_s5  (vbeta_s5)
	);

	foc_svpwm u_svpwm (
		.clk           (clk),
		.ce            (pipe_ce),
		.volt_alpha_s5 (valpha_s5),
		.volt_beta_s5  (vbeta_s5),
		.pwm_period    (pwm_period_q),
		.compare_s12   (compare_s12)
	);

	// align d/q currents with the compare counts
	always_ff @(posedge clk) begin
		if (pipe_ce) begin
			cur_d_s[PARK_LAT+1] <= park_d_s5;
			cur_q_s[PARK_LAT+1] <= park_q_s5;
			for (int k = PARK_LAT + 2; k <= LAT; k++) begin
				cur_d_s[k] <= cur_d_s[k-1];
				cur_q_s[k] <= cur_q_s[k-1];
			end
		end
	end

	assign result_s12 = {compare_s12[2], compare_s12[1], compare_s12[0],
		cur_q_s[LAT], cur_d_s[LAT]};

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= valid_s[LAT];
			end
		end else if (pipe_ce && valid_s[LAT]) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_data_q <= skid_valid_q ? skid_data_q : result_s12;
		end else if (pipe_ce) begin
			skid_data_q <= result_s12;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

// File: hdl/foc_chk.sv
`default_nettype none

module foc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output item changed while stalled");

	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result shown right after reset");

	a_skid_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input held off with empty output register");

	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("input held off without an output stall");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready && m_tready |=> s_tready)
		else $error("skid entry not released after output taken");

endmodule

bind foc_transform_svpwm foc_chk u_foc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int SINE_DEPTH = 1024;
	localparam int PHASE_SAMPLES = 168;

	typedef struct packed {
		foc_pkg::q15_t volt_q;
		foc_pkg::q15_t volt_d;
		foc_pkg::q15_t current_c;
		foc_pkg::q15_t current_b;
		foc_pkg::q15_t current_a;
		logic [15:0]   rotor_angle;
	} sample_t;

	typedef struct packed {
		logic [15:0]   compare_c;
		logic [15:0]   compare_b;
		logic [15:0]   compare_a;
		foc_pkg::q15_t current_q;
		foc_pkg::q15_t current_d;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;      // rotor_angle, current_a, current_b, current_c, volt_d, volt_q
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;           // current_d, current_q, compare_a, compare_b, compare_c
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;  // pwm_period

	foc_transform_svpwm #(
		.SINE_TABLE_DEPTH(SINE_DEPTH)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	int          sine_lut [0:SINE_DEPTH];
	sample_t     pending_samples [$];
	frame_t      predicted_frames [$];
	logic [15:0] period_shadow = foc_pkg::PWM_PERIOD_RESET;
	bit          traffic_gaps = 1'b1;
	int          send_gap = 0;
	int          stall_left = 0;
	int          err_count = 0;

	function automatic int sine_q15(int k);
		longint unsigned t, x, x2, term, r, n;
		longint sum;
		t = (longint'(k) << 30) / SINE_DEPTH;
		x = (t * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
			if (n[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		r = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (r > 32767)
			r = 32767;
		return int'(r);
	endfunction

	// floor((v + 2^(n-1)) / 2^n)
	function automatic longint round_q(longint v, int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic longint sat16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic frame_t transform_and_modulate(sample_t smp, logic [15:0] period);
		longint s, c, ia, ib, ic, vd, vq, beta, valpha, vbeta;
		longint half, kv, vmax, vmin, p, w;
		longint ph [3];
		longint cnt [3];
		int idx;
		frame_t f;
		idx = (int'(smp.rotor_angle[13:0]) * SINE_DEPTH) >> 14;
		case (smp.rotor_angle[15:14])
			2'd0: begin
				s = sine_lut[idx];
				c = sine_lut[SINE_DEPTH - idx];
			end
			2'd1: begin
				s = sine_lut[SINE_DEPTH - idx];
				c = -sine_lut[idx];
			end
			2'd2: begin
				s = -sine_lut[idx];
				c = -sine_lut[SINE_DEPTH - idx];
			end
			default: begin
				s = -sine_lut[SINE_DEPTH - idx];
				c = sine_lut[idx];
			end
		endcase
		ia = longint'(smp.current_a);
		ib = longint'(smp.current_b);
		ic = longint'(smp.current_c);
		vd = longint'(smp.volt_d);
		vq = longint'(smp.volt_q);

		beta = round_q((ib - ic) * longint'(foc_pkg::INV_SQRT3_Q15), 15);
		f.current_d = foc_pkg::q15_t'(sat16(round_q(ia * c + beta * s, 15)));
		f.current_q = foc_pkg::q15_t'(sat16(round_q(beta * c - ia * s, 15)));

		valpha = round_q(vd * c - vq * s, 15);
		vbeta = round_q(vd * s + vq * c, 15);

		// phase vectors in Q30
		half = valpha * 16384;
		kv = vbeta * longint'(foc_pkg::SQRT3_HALF_Q15);
		ph[0] = valpha * 32768;
		ph[1] = -half + kv;
		ph[2] = -half - kv;
		vmax = ph[0];
		vmin = ph[0];
		for (int j = 1; j < 3; j++) begin
			if (ph[j] > vmax)
				vmax = ph[j];
			if (ph[j] < vmin)
				vmin = ph[j];
		end

		p = longint'(period);
		for (int j = 0; j < 3; j++) begin
			w = round_q(((longint'(1) << 30) + vmax + vmin - 2 * ph[j]) * p, 31);
			if (w < 0)
				w = 0;
			if (w > p)
				w = p;
			cnt[j] = w;
		end
		f.compare_a = cnt[0][15:0];
		f.compare_b = cnt[1][15:0];
		f.compare_c = cnt[2][15:0];
		return f;
	endfunction

	function automatic logic [15:0] pick_field();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: begin
				if ($urandom_range(0, 1))
					return 16'($urandom_range(0, 255));
				return -16'($urandom_range(1, 256));
			end
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic sample_t random_sample();
		sample_t smp;
		case ($urandom_range(0, 5))
			0: smp.rotor_angle = {2'($urandom), 14'($urandom_range(0, 31))};
			1: smp.rotor_angle = {2'($urandom), 14'h3FFF - 14'($urandom_range(0, 31))};
			default: smp.rotor_angle = 16'($urandom);
		endcase
		if ($urandom_range(0, 2) == 0) begin
			smp.current_a = pick_field();
			smp.current_b = pick_field();
			smp.current_c = pick_field();
			smp.volt_d = pick_field();
			smp.volt_q = pick_field();
		end else begin
			smp.current_a = 16'($urandom);
			smp.current_b = 16'($urandom);
			smp.current_c = 16'($urandom);
			smp.volt_d = 16'($urandom);
			smp.volt_q = 16'($urandom);
		end
		return smp;
	endfunction

	task automatic queue_sample(logic [15:0] angle, foc_pkg::q15_t ia,
		foc_pkg::q15_t ib, foc_pkg::q15_t ic, foc_pkg::q15_t vd, foc_pkg::q15_t vq);
		sample_t smp;
		smp.rotor_angle = angle;
		smp.current_a = ia;
		smp.current_b = ib;
		smp.current_c = ic;
		smp.volt_d = vd;
		smp.volt_q = vq;
		pending_samples.push_back(smp);
	endtask

	task automatic drain();
		while (pending_samples.size() != 0 || s_tvalid || predicted_frames.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_period(logic [15:0] value);
		@(posedge clk);
		cfg_wr_data <= value;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			err_count++;
			if (err_count <= 10)
				$display("tb: %s mismatch, expected %h got %h", name, want, got);
		end
	endtask

	// sender: gaps are only inserted between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				s_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (traffic_gaps && pending_samples.size() != 0 &&
				$urandom_range(0, 9) == 0) begin
				s_tvalid <= 1'b0;
				send_gap <= $urandom_range(0, 7);
			end else if (pending_samples.size() != 0) begin
				s_tdata <= pending_samples.pop_front();
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (traffic_gaps && $urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 7);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		frame_t got, want;
		if (arst_n) begin
			if (cfg_wr_en)
				period_shadow = cfg_wr_data;
			if (s_tvalid && s_tready)
				predicted_frames.push_back(transform_and_modulate(sample_t'(s_tdata), period_shadow));
			if (m_tvalid && m_tready) begin
				got = frame_t'(m_tdata);
				if (predicted_frames.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("tb: unexpected item %h", m_tdata);
				end else begin
					want = predicted_frames.pop_front();
					check_field("current_d", want.current_d, got.current_d);
					check_field("current_q", want.current_q, got.current_q);
					check_field("compare_a", want.compare_a, got.compare_a);
					check_field("compare_b", want.compare_b, got.compare_b);
					check_field("compare_c", want.compare_c, got.compare_c);
				end
			end
		end
	end

	initial begin
		logic [15:0] period;
		for (int k = 0; k <= SINE_DEPTH; k++)
			sine_lut[k] = sine_q15(k);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset period, directed corners
		queue_sample(16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
		queue_sample(16'h3FFF, 16'sd1000, -16'sd2000, 16'sd3000, 16'sd8000, 16'sd4000);
		queue_sample(16'h4000, 16'sd1000, -16'sd2000, 16'sd3000, 16'sd8000, 16'sd4000);
		queue_sample(16'h7FFF, 16'sd1000, -16'sd2000, 16'sd3000, 16'sd8000, 16'sd4000);
		queue_sample(16'h8000, 16'sd1000, -16'sd2000, 16'sd3000, 16'sd8000, 16'sd4000);
		queue_sample(16'hBFFF, 16'sd1000, -16'sd2000, 16'sd3000, 16'sd8000, 16'sd4000);
		queue_sample(16'hC000, 16'sd1000, -16'sd2000, 16'sd3000, 16'sd8000, 16'sd4000);
		queue_sample(16'hFFFF, 16'sd1000, -16'sd2000, 16'sd3000, 16'sd8000, 16'sd4000);
		// Park outputs driven into saturation
		queue_sample(16'h2000, 16'h8000, 16'h7FFF, 16'h8000, 16'sd0, 16'sd0);
		queue_sample(16'h2000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'sd0, 16'sd0);
		queue_sample(16'hA000, 16'h8000, 16'h7FFF, 16'h8000, 16'sd0, 16'sd0);
		queue_sample(16'h6000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
		// voltage extremes, wide alpha/beta and compare clamping
		queue_sample(16'h2000, 16'sd0, 16'sd0, 16'sd0, 16'h7FFF, 16'h7FFF);
		queue_sample(16'hA000, 16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h8000);
		queue_sample(16'h1000, 16'sd0, 16'sd0, 16'sd0, 16'h7FFF, 16'h8000);
		queue_sample(16'hE000, 16'sd0, 16'sd0, 16'sd0, 16'h8000, 16'h7FFF);
		queue_sample(16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h7FFF);
		queue_sample(16'h5555, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'sd0);
		queue_sample(16'h9000, 16'sd1, -16'sd1, 16'sd1, 16'sd1, -16'sd1);
		queue_sample(16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		drain();

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: period = 16'hFFFF;
				1: period = 16'd1;
				2: period = 16'd0;
				5: period = 16'd20000;
				6: period = foc_pkg::PWM_PERIOD_RESET;
				default: period = 16'($urandom_range(2, 65534));
			endcase
			set_period(period);
			traffic_gaps = (phase != 3 && phase != 6);
			for (int n = 0; n < PHASE_SAMPLES; n++)
				pending_samples.push_back(random_sample());
			drain();
		end

		if (predicted_frames.size() != 0)
			err_count++;
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// File: sim.f
hdl/foc_pkg.sv
hdl/foc_sincos.sv
hdl/foc_park.sv
hdl/foc_svpwm.sv
hdl/foc_transform_svpwm.sv
hdl/foc_chk.sv
bench/tb.sv
